[design/dbsd_pkg.sv]
// shared types and constants of the deflate block split decider
`default_nettype none
package dbsd_pkg;

   // histogram shape
   localparam int NUM_CLASSES = 10;
   localparam int CLASS_W     = $clog2(NUM_CLASSES);
   localparam int LENGTH_WIDTH = 24;

   // symbol class layout
   localparam logic [CLASS_W-1:0] MATCH_SHORT_CLASS = CLASS_W'(8);
   localparam logic [CLASS_W-1:0] MATCH_LONG_CLASS  = CLASS_W'(9);
   localparam logic [8:0]         LONG_MATCH_MIN    = 9'd9;

   // cutoff arithmetic
   localparam logic [31:0] CUT_SCALE      = 32'd200;
   localparam int          CUT_SHIFT      = 9;
   localparam logic [31:0] LOOSEN_ITEMS   = 32'd8192;
   localparam int          LOOSEN_SHIFT   = 13;
   localparam int          LOOSEN_K_W     = 14;
   localparam logic [LENGTH_WIDTH-1:0] LOOSEN_CUR = LENGTH_WIDTH'(10000);
   localparam int          CUR_SHIFT      = 12;

   // configuration registers
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_BLOCK_LENGTH = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OBS_PER_CHECK    = 8'd1;
   localparam logic [15:0] MIN_BLOCK_LENGTH_RESET = 16'd5000;
   localparam logic [15:0] OBS_PER_CHECK_RESET    = 16'd512;

   typedef enum logic [1:0] {
      OP_LITERAL = 2'd0,
      OP_MATCH   = 2'd1,
      OP_CHECK   = 2'd2,
      OP_CLEAR   = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type              opcode;
      logic [7:0]              literal_byte;
      logic [8:0]              match_length;
      logic [LENGTH_WIDTH-1:0] current_length;
      logic [LENGTH_WIDTH-1:0] remaining_length;
   } req_type;

   typedef struct packed {
      logic end_block;
      logic merged;
   } rsp_type;

endpackage
`default_nettype wire

[design/deflate_block_split_decider_unit.sv]
// deflate block split decider: class histograms and split check sequencer
`default_nettype none
// Literal, match and clear requests leave busy low and may be issued back to
// back, each result strobed on rsp_valid in the cycle after acceptance. A
// check request that is not ready (too few new observations or a length too
// short), or that finds an empty old histogram, also answers in the next
// cycle. A full check walks the ten classes through one shared 32x32
// multiplier, two products per class, then six more steps for the cutoff and
// metric and one to decide: busy stays high through the decide step, which
// registers the result onto rsp_valid. The result is strobed for one cycle
// only and cannot be held off; the receiver must take it when rsp_valid is
// high.
module deflate_block_split_decider_unit (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  dbsd_pkg::req_type req_item,
   output logic              rsp_valid,
   output dbsd_pkg::rsp_type rsp_item,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire [dbsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [15:0]        csr_wdata
);

   localparam int NC  = dbsd_pkg::NUM_CLASSES;
   localparam int CW  = dbsd_pkg::CLASS_W;
   localparam int LW  = dbsd_pkg::LENGTH_WIDTH;
   localparam int KW  = dbsd_pkg::LOOSEN_K_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXP,
      S_ACT,
      S_SCALE,
      S_BASE,
      S_CUTLO,
      S_CUTHI,
      S_ADJ,
      S_METRIC,
      S_DECIDE
   } state_type;

   state_type       state_ff, state_in;
   logic [31:0]     old_ff [NC];
   logic [31:0]     old_in [NC];
   logic [31:0]     new_ff [NC];
   logic [31:0]     new_in [NC];
   logic [31:0]     old_total_ff, old_total_in;
   logic [31:0]     new_total_ff, new_total_in;
   logic [15:0]     min_len_ff, min_len_in;
   logic [15:0]     obs_ff, obs_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [LW-1:0]   cur_ff, cur_in;
   logic [31:0]     exp_ff, exp_in;
   logic [31:0]     delta_ff, delta_in;
   logic [63:0]     prod_ff, prod_in;
   logic [63:0]     cutoff_ff, cutoff_in;
   logic [63:0]     tmp_ff, tmp_in;
   logic [63:0]     adj_ff, adj_in;
   logic [63:0]     metric_ff, metric_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_end_ff, rsp_end_in;
   logic            rsp_merged_ff, rsp_merged_in;

   logic            accept;
   logic [CW-1:0]   cls;
   logic            check_ready;
   logic [31:0]     mul_a, mul_b;
   logic [31:0]     act;
   logic [31:0]     diff;
   logic [31:0]     items;
   logic [KW-1:0]   loosen_k;
   logic            loosen;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = '{end_block: rsp_end_ff, merged: rsp_merged_ff};

   // symbol class of the incoming observation
   always_comb begin
      if (req_item.opcode == dbsd_pkg::OP_LITERAL) begin
         cls = CW'({req_item.literal_byte[7:6], req_item.literal_byte[0]});
      end else if (req_item.match_length >= dbsd_pkg::LONG_MATCH_MIN) begin
         cls = dbsd_pkg::MATCH_LONG_CLASS;
      end else begin
         cls = dbsd_pkg::MATCH_SHORT_CLASS;
      end
   end

   // check gating on observation count and both lengths
   assign check_ready = (new_total_ff >= {16'd0, obs_ff})
                     && (req_item.current_length >= LW'(min_len_ff))
                     && (req_item.remaining_length >= LW'(min_len_ff));

   // distance between the two cross products of one class
   assign act  = prod_ff[31:0];
   assign diff = (act > exp_ff) ? (act - exp_ff) : (exp_ff - act);

   // loosening factor for short blocks
   assign items    = old_total_ff + new_total_ff;
   assign loosen_k = KW'(dbsd_pkg::LOOSEN_ITEMS) - items[KW-1:0];
   assign loosen   = (cur_ff < dbsd_pkg::LOOSEN_CUR)
                  && (items < dbsd_pkg::LOOSEN_ITEMS);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_EXP: begin
            mul_a = old_ff[idx_ff];
            mul_b = new_total_ff;
         end
         S_ACT: begin
            mul_a = new_ff[idx_ff];
            mul_b = old_total_ff;
         end
         S_SCALE: begin
            mul_a = new_total_ff;
            mul_b = dbsd_pkg::CUT_SCALE;
         end
         S_BASE: begin
            mul_a = prod_ff[dbsd_pkg::CUT_SHIFT +: 32];
            mul_b = old_total_ff;
         end
         S_CUTLO: begin
            mul_a = prod_ff[31:0];
            mul_b = 32'(loosen_k);
         end
         S_CUTHI: begin
            mul_a = cutoff_ff[63:32];
            mul_b = 32'(loosen_k);
         end
         S_ADJ: begin
            mul_a = 32'(cur_ff >> dbsd_pkg::CUR_SHIFT);
            mul_b = old_total_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      old_in        = old_ff;
      new_in        = new_ff;
      old_total_in  = old_total_ff;
      new_total_in  = new_total_ff;
      min_len_in    = min_len_ff;
      obs_in        = obs_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      exp_in        = exp_ff;
      delta_in      = delta_ff;
      cutoff_in     = cutoff_ff;
      tmp_in        = tmp_ff;
      adj_in        = adj_ff;
      metric_in     = metric_ff;
      rsp_valid_in  = 1'b0;
      rsp_end_in    = 1'b0;
      rsp_merged_in = 1'b0;

      // configuration writes
      if (csr_valid && csr_ready) begin
         if (csr_index == dbsd_pkg::CSR_MIN_BLOCK_LENGTH) begin
            min_len_in = csr_wdata;
         end else if (csr_index == dbsd_pkg::CSR_OBS_PER_CHECK) begin
            obs_in = csr_wdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_item.opcode)
                  dbsd_pkg::OP_LITERAL, dbsd_pkg::OP_MATCH: begin
                     new_in[cls]  = new_ff[cls] + 32'd1;
                     new_total_in = new_total_ff + 32'd1;
                  end
                  dbsd_pkg::OP_CLEAR: begin
                     for (int i = 0; i < NC; i++) begin
                        old_in[i] = '0;
                        new_in[i] = '0;
                     end
                     old_total_in = '0;
                     new_total_in = '0;
                  end
                  dbsd_pkg::OP_CHECK: begin
                     if (check_ready) begin
                        if (old_total_ff == '0) begin
                           for (int i = 0; i < NC; i++) begin
                              old_in[i] = old_ff[i] + new_ff[i];
                              new_in[i] = '0;
                           end
                           old_total_in  = old_total_ff + new_total_ff;
                           new_total_in  = '0;
                           rsp_merged_in = 1'b1;
                        end else begin
                           rsp_valid_in = 1'b0;
                           cur_in       = req_item.current_length;
                           idx_in       = '0;
                           delta_in     = '0;
                           state_in     = S_EXP;
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         // fold in the previous class, issue expected count
         S_EXP: begin
            if (idx_ff != '0) begin
               delta_in = delta_ff + diff;
            end
            state_in = S_ACT;
         end
         // hold expected, issue actual count
         S_ACT: begin
            exp_in = prod_ff[31:0];
            if (idx_ff == CW'(NC - 1)) begin
               state_in = S_SCALE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_EXP;
            end
         end
         S_SCALE: begin
            delta_in = delta_ff + diff;
            state_in = S_BASE;
         end
         S_BASE: begin
            state_in = S_CUTLO;
         end
         S_CUTLO: begin
            cutoff_in = prod_ff;
            state_in  = S_CUTHI;
         end
         S_CUTHI: begin
            tmp_in   = prod_ff;
            state_in = S_ADJ;
         end
         // low partial plus high partial, both modulo 2^64
         S_ADJ: begin
            adj_in   = tmp_ff + {prod_ff[31:0], 32'd0};
            state_in = S_METRIC;
         end
         S_METRIC: begin
            if (loosen) begin
               cutoff_in = cutoff_ff + (adj_ff >> dbsd_pkg::LOOSEN_SHIFT);
            end
            metric_in = {32'd0, delta_ff} + prod_ff;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            rsp_valid_in = 1'b1;
            if (metric_ff >= cutoff_ff) begin
               rsp_end_in = 1'b1;
            end else begin
               for (int i = 0; i < NC; i++) begin
                  old_in[i] = old_ff[i] + new_ff[i];
                  new_in[i] = '0;
               end
               old_total_in  = old_total_ff + new_total_ff;
               new_total_in  = '0;
               rsp_merged_in = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, histograms and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         for (int i = 0; i < NC; i++) begin
            old_ff[i] <= '0;
            new_ff[i] <= '0;
         end
         old_total_ff  <= '0;
         new_total_ff  <= '0;
         min_len_ff    <= dbsd_pkg::MIN_BLOCK_LENGTH_RESET;
         obs_ff        <= dbsd_pkg::OBS_PER_CHECK_RESET;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_end_ff    <= 1'b0;
         rsp_merged_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         old_ff        <= old_in;
         new_ff        <= new_in;
         old_total_ff  <= old_total_in;
         new_total_ff  <= new_total_in;
         min_len_ff    <= min_len_in;
         obs_ff        <= obs_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_merged_ff <= rsp_merged_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      exp_ff    <= exp_in;
      delta_ff  <= delta_in;
      prod_ff   <= prod_in;
      cutoff_ff <= cutoff_in;
      tmp_ff    <= tmp_in;
      adj_ff    <= adj_in;
      metric_ff <= metric_in;
   end

endmodule
`default_nettype wire

[design/dbsd_checker.sv]
// port-level checks of the deflate block split decider and their bind
`default_nettype none
module dbsd_checker (
   input wire               clock,
   input wire               reset,
   input wire               start,
   input wire               busy,
   input dbsd_pkg::req_type req_item,
   input wire               rsp_valid,
   input dbsd_pkg::rsp_type rsp_item
);

   // observe and clear requests answer in the next cycle with no decision
   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.opcode != dbsd_pkg::OP_CHECK)
      |=> (rsp_valid && !rsp_item.end_block && !rsp_item.merged))
      else $error("observe or clear request did not answer plainly");

   // a check never both ends the block and merges
   a_one_decision: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.end_block && rsp_item.merged))
      else $error("end_block and merged both set");

   // a result only follows an accepted request or a running check
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start && !busy) || $past(busy)))
      else $error("result without a request");

   // the sequencer only starts on a check request
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> ($past(start) && $past(req_item.opcode) == dbsd_pkg::OP_CHECK))
      else $error("busy without a check request");

   // a result ends the busy period
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

endmodule

bind deflate_block_split_decider_unit dbsd_checker u_dbsd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire

[tb/split_decision_checker.sv]
// checker for the block split decider: tracks both histograms and checks each decision
`default_nettype none
module split_decision_checker (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire                             busy,
   input  dbsd_pkg::req_type               req_item,
   input  wire                             rsp_valid,
   input  dbsd_pkg::rsp_type               rsp_item,
   input  wire                             csr_valid,
   input  wire                             csr_ready,
   input  wire [dbsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [15:0]                      csr_wdata,
   output logic [31:0]                     fail_count,
   output logic [31:0]                     pending_decisions
);

   // shadow histograms, totals and register copies
   logic [31:0] old_counts [dbsd_pkg::NUM_CLASSES];
   logic [31:0] new_counts [dbsd_pkg::NUM_CLASSES];
   logic [31:0] old_total;
   logic [31:0] new_total;
   logic [15:0] min_len;
   logic [15:0] obs_needed;

   // decisions predicted for accepted requests, oldest first
   dbsd_pkg::rsp_type decision_q [$];

   function automatic void clear_histograms();
      for (int i = 0; i < dbsd_pkg::NUM_CLASSES; i++) begin
         old_counts[i] = '0;
         new_counts[i] = '0;
      end
      old_total = '0;
      new_total = '0;
   endfunction

   function automatic void count_symbol(input int cls);
      new_counts[cls] = new_counts[cls] + 32'd1;
      new_total = new_total + 32'd1;
   endfunction

   // advance the shadow state by one request and work out its decision
   task automatic predict_decision(input dbsd_pkg::req_type r, output dbsd_pkg::rsp_type d);
      logic [31:0] cur32;
      logic [31:0] rem32;
      logic [31:0] delta;
      logic [31:0] items;
      logic [31:0] scaled_old;
      logic [31:0] scaled_new;
      logic [63:0] cutoff;
      logic [63:0] widen;
      logic [63:0] metric;
      logic        stop;
      begin
         d = '0;
         cur32 = 32'(r.current_length);
         rem32 = 32'(r.remaining_length);
         case (r.opcode)
            dbsd_pkg::OP_LITERAL: begin
               count_symbol(int'({r.literal_byte[7:6], r.literal_byte[0]}));
            end
            dbsd_pkg::OP_MATCH: begin
               if (r.match_length >= dbsd_pkg::LONG_MATCH_MIN)
                  count_symbol(int'(dbsd_pkg::MATCH_LONG_CLASS));
               else
                  count_symbol(int'(dbsd_pkg::MATCH_SHORT_CLASS));
            end
            dbsd_pkg::OP_CLEAR: begin
               clear_histograms();
            end
            default: begin
               // check: evaluated only with enough observations and long enough lengths
               if (new_total >= 32'(obs_needed) && cur32 >= 32'(min_len) &&
                   rem32 >= 32'(min_len)) begin
                  stop = 1'b0;
                  if (old_total != 0) begin
                     delta = '0;
                     for (int i = 0; i < dbsd_pkg::NUM_CLASSES; i++) begin
                        scaled_old = old_counts[i] * new_total;
                        scaled_new = new_counts[i] * old_total;
                        delta = delta + ((scaled_new > scaled_old) ?
                                         (scaled_new - scaled_old) :
                                         (scaled_old - scaled_new));
                     end
                     items = old_total + new_total;
                     cutoff = ((64'(new_total) * 64'(dbsd_pkg::CUT_SCALE))
                               >> dbsd_pkg::CUT_SHIFT) * 64'(old_total);
                     // short blocks get a looser cutoff
                     if (cur32 < 32'(dbsd_pkg::LOOSEN_CUR) &&
                         items < dbsd_pkg::LOOSEN_ITEMS) begin
                        widen = cutoff * 64'(dbsd_pkg::LOOSEN_ITEMS - items);
                        cutoff = cutoff + (widen >> dbsd_pkg::LOOSEN_SHIFT);
                     end
                     metric = 64'(delta) +
                              64'(cur32 >> dbsd_pkg::CUR_SHIFT) * 64'(old_total);
                     stop = (metric >= cutoff);
                  end
                  if (stop) begin
                     d.end_block = 1'b1;
                  end else begin
                     for (int i = 0; i < dbsd_pkg::NUM_CLASSES; i++) begin
                        old_counts[i] = old_counts[i] + new_counts[i];
                        new_counts[i] = '0;
                     end
                     old_total = old_total + new_total;
                     new_total = '0;
                     d.merged = 1'b1;
                  end
               end
            end
         endcase
      end
   endtask

   // watch results, register writes and requests at each rising edge
   always @(posedge clock) begin : watch
      dbsd_pkg::rsp_type want;
      dbsd_pkg::rsp_type got;
      if (reset) begin
         clear_histograms();
         min_len = dbsd_pkg::MIN_BLOCK_LENGTH_RESET;
         obs_needed = dbsd_pkg::OBS_PER_CHECK_RESET;
         decision_q.delete();
         fail_count = '0;
         pending_decisions = '0;
      end else begin
         // compare each result with the oldest prediction
         if (rsp_valid) begin
            got = rsp_item;
            if (decision_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected decision end_block=%0b merged=%0b, none pending",
                           got.end_block, got.merged);
               fail_count = fail_count + 1;
            end else begin
               want = decision_q.pop_front();
               pending_decisions = pending_decisions - 1;
               if (got.end_block !== want.end_block || got.merged !== want.merged) begin
                  if (fail_count < 10)
                     $display("decision mismatch: expected end_block=%0b merged=%0b, got end_block=%0b merged=%0b",
                              want.end_block, want.merged, got.end_block, got.merged);
                  fail_count = fail_count + 1;
               end
            end
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dbsd_pkg::CSR_MIN_BLOCK_LENGTH: min_len = csr_wdata;
               dbsd_pkg::CSR_OBS_PER_CHECK:    obs_needed = csr_wdata;
               default: ;
            endcase
         end
         // accepted request
         if (start && !busy) begin
            predict_decision(req_item, want);
            decision_q.push_back(want);
            pending_decisions = pending_decisions + 1;
         end
      end
   end

endmodule
`default_nettype wire

[tb/testbench.sv]
// top of the block split decider testbench: clock, reset, stimulus and verdict
`default_nettype none
module testbench;

   // run limit, well above the worst case (every request a full check plus gaps)
   localparam int CYCLE_LIMIT = 400000;

   logic                             clock;
   logic                             reset;
   logic                             start;
   wire                              busy;
   dbsd_pkg::req_type                req_item;
   wire                              rsp_valid;
   dbsd_pkg::rsp_type                rsp_item;
   logic                             csr_valid;
   wire                              csr_ready;
   logic [dbsd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [15:0]                      csr_wdata;
   wire  [31:0]                      fail_count;
   wire  [31:0]                      pending_decisions;

   // stimulus state
   int          cycle_count = 0;
   int          cfg_min_len;
   logic [2:0]  fav_class;
   bit          gaps_on;
   int          sent_total;
   int          sent_checks;
   int          sent_clears;
   int          settings_used;

   deflate_block_split_decider_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   split_decision_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_item          (req_item),
      .rsp_valid         (rsp_valid),
      .rsp_item          (rsp_item),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending_decisions (pending_decisions)
   );

   // clock, period 20
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // run timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic dbsd_pkg::req_type make_req(input dbsd_pkg::opcode_type op,
                                                  input logic [7:0] lit,
                                                  input logic [8:0] mlen,
                                                  input logic [23:0] cur,
                                                  input logic [23:0] rem);
      dbsd_pkg::req_type r;
      r.opcode = op;
      r.literal_byte = lit;
      r.match_length = mlen;
      r.current_length = cur;
      r.remaining_length = rem;
      return r;
   endfunction

   // lengths mostly at or above the split minimum, some just below, some anywhere
   function automatic logic [23:0] pick_length();
      logic [31:0] v;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         v = (cfg_min_len == 0) ? 32'd0 : 32'(cfg_min_len - 1);
      end else if (pick < 70) begin
         if ($urandom_range(1) == 0)
            v = 32'(cfg_min_len) + $urandom_range(12000, 0);
         else
            v = 32'(cfg_min_len) + $urandom_range(24'hFFFFFF, 0);
         if (v > 32'hFFFFFF)
            v = 32'hFFFFFF;
      end else begin
         v = $urandom_range(24'hFFFFFF, 0);
      end
      return v[23:0];
   endfunction

   // observation runs with a favored literal class, broken up by checks and clears
   function automatic dbsd_pkg::req_type random_request();
      dbsd_pkg::req_type r;
      logic [7:0]        rnd;
      int                pick;
      rnd = 8'($urandom);
      r.literal_byte = ($urandom_range(1) == 0) ? rnd :
                       {fav_class[2:1], rnd[5:1], fav_class[0]};
      r.match_length = ($urandom_range(1) == 0) ? 9'($urandom_range(8, 0)) :
                       9'($urandom_range(258, 9));
      r.current_length = pick_length();
      r.remaining_length = pick_length();
      pick = $urandom_range(99);
      if (pick < 55)
         r.opcode = dbsd_pkg::OP_LITERAL;
      else if (pick < 77)
         r.opcode = dbsd_pkg::OP_MATCH;
      else if (pick < 94)
         r.opcode = dbsd_pkg::OP_CHECK;
      else
         r.opcode = dbsd_pkg::OP_CLEAR;
      return r;
   endfunction

   // present one request and hold it until accepted
   task automatic drive_request(input dbsd_pkg::req_type item);
      begin
         while (gaps_on && $urandom_range(99) < 24) begin
            start <= 1'b0;
            @(negedge clock);
         end
         start <= 1'b1;
         req_item <= item;
         @(posedge clock);
         while (busy)
            @(posedge clock);
         @(negedge clock);
         sent_total++;
         if (item.opcode == dbsd_pkg::OP_CHECK)
            sent_checks++;
         if (item.opcode == dbsd_pkg::OP_CLEAR)
            sent_clears++;
      end
   endtask

   // stop sending and wait until every predicted decision has come back
   task automatic settle();
      begin
         start <= 1'b0;
         while (pending_decisions != 0)
            @(negedge clock);
         repeat (4) @(negedge clock);
      end
   endtask

   task automatic write_register(input logic [dbsd_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [15:0] value);
      begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         @(negedge clock);
         csr_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   // write both registers in random order
   task automatic program_split(input logic [15:0] min_len, input logic [15:0] obs);
      begin
         if ($urandom_range(1) == 0) begin
            write_register(dbsd_pkg::CSR_MIN_BLOCK_LENGTH, min_len);
            write_register(dbsd_pkg::CSR_OBS_PER_CHECK, obs);
         end else begin
            write_register(dbsd_pkg::CSR_OBS_PER_CHECK, obs);
            write_register(dbsd_pkg::CSR_MIN_BLOCK_LENGTH, min_len);
         end
         cfg_min_len = int'(min_len);
         settings_used++;
      end
   endtask

   task automatic run_phase(input logic [15:0] min_len, input logic [15:0] obs,
                            input bit gaps, input int count);
      begin
         settle();
         program_split(min_len, obs);
         gaps_on = gaps;
         for (int n = 0; n < count; n++) begin
            if ($urandom_range(19) == 0)
               fav_class = 3'($urandom_range(7));
            drive_request(random_request());
         end
      end
   endtask

   initial begin : stimulus
      logic [7:0] corner_bytes [8];
      logic [8:0] corner_lengths [5];
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = dbsd_pkg::CSR_MIN_BLOCK_LENGTH;
      csr_wdata = '0;
      cfg_min_len = int'(dbsd_pkg::MIN_BLOCK_LENGTH_RESET);
      fav_class = '0;
      gaps_on = 1'b1;
      sent_total = 0;
      sent_checks = 0;
      sent_clears = 0;
      settings_used = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // literal classes 0, 1, 2, 5, 6 and 7, with bit 5 set and clear to show it is masked
      corner_bytes = '{8'h00, 8'h01, 8'h3E, 8'h21, 8'h40, 8'h81, 8'hC0, 8'hFF};
      foreach (corner_bytes[i])
         drive_request(make_req(dbsd_pkg::OP_LITERAL, corner_bytes[i], '0, '0, '0));
      // match lengths around the short/long split
      corner_lengths = '{9'd0, 9'd8, 9'd9, 9'd255, 9'd258};
      foreach (corner_lengths[i])
         drive_request(make_req(dbsd_pkg::OP_MATCH, '0, corner_lengths[i], '0, '0));
      // check at reset settings: too few observations
      drive_request(make_req(dbsd_pkg::OP_CHECK, '0, '0, 24'hFFFFFF, 24'hFFFFFF));
      drive_request(make_req(dbsd_pkg::OP_CLEAR, '0, '0, '0, '0));

      // loosest settings
      settle();
      program_split(16'd1, 16'd1);
      // check with no observations, then a check on an empty old histogram
      drive_request(make_req(dbsd_pkg::OP_CHECK, '0, '0, 24'd1, 24'd1));
      drive_request(make_req(dbsd_pkg::OP_LITERAL, 8'h00, '0, '0, '0));
      drive_request(make_req(dbsd_pkg::OP_CHECK, '0, '0, 24'd1, 24'd1));
      // current, then remaining length too short; then a differing split that ends the block
      drive_request(make_req(dbsd_pkg::OP_LITERAL, 8'hFF, '0, '0, '0));
      drive_request(make_req(dbsd_pkg::OP_CHECK, '0, '0, 24'd0, 24'hFFFFFF));
      drive_request(make_req(dbsd_pkg::OP_CHECK, '0, '0, 24'hFFFFFF, 24'd0));
      drive_request(make_req(dbsd_pkg::OP_CHECK, '0, '0, 24'd1, 24'd1));
      drive_request(make_req(dbsd_pkg::OP_CLEAR, '0, '0, '0, '0));
      // largest lengths: no loosening, current length term in the metric
      drive_request(make_req(dbsd_pkg::OP_LITERAL, 8'h00, '0, '0, '0));
      drive_request(make_req(dbsd_pkg::OP_CHECK, '0, '0, 24'hFFFFFF, 24'hFFFFFF));
      drive_request(make_req(dbsd_pkg::OP_MATCH, '0, 9'd3, '0, '0));
      drive_request(make_req(dbsd_pkg::OP_CHECK, '0, '0, 24'hFFFFFF, 24'hFFFFFF));

      // random phases over several register settings, two consecutive ones without gaps
      run_phase(16'd1, 16'd1, 1'b1, 150);
      run_phase(16'd65535, 16'd3, 1'b1, 140);
      run_phase(16'd37, 16'd65535, 1'b0, 110);
      run_phase(16'($urandom_range(12000, 1)), 16'($urandom_range(24, 1)), 1'b0, 160);
      run_phase(16'd9999, 16'd2, 1'b1, 150);
      run_phase(16'($urandom_range(300, 1)), 16'($urandom_range(12, 1)), 1'b1, 170);

      // drain and let the block go quiet
      settle();
      repeat (40) @(negedge clock);

      $display("sent %0d requests (%0d checks, %0d clears) under %0d register settings",
               sent_total, sent_checks, sent_clears, settings_used);
      $display("both registers taken to 1 and 65535, with and without sender gaps");
      if (fail_count == 0 && pending_decisions == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire

[deflate_block_split_decider_unit.f]
design/dbsd_pkg.sv
design/deflate_block_split_decider_unit.sv
design/dbsd_checker.sv
tb/split_decision_checker.sv
tb/testbench.sv
